FILE: rtl/tpss_pkg.sv
package tpss_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;
  localparam int MASK_W = 32;
  localparam int IDX_CMP_W = 7;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_REGISTER = 2'd1,
    OP_STOP     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_INVALID  = 3'd0,
    KIND_PERIODIC = 3'd1,
    KIND_EVENT    = 3'd2,
    KIND_CALLBACK = 3'd3,
    KIND_MONITOR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CODE_OK      = 2'd0,
    CODE_REJECT  = 2'd1,
    CODE_STOPPED = 2'd2
  } code_t;

  typedef struct packed {
    logic release_hit;
    logic fire_hit;
    logic miss_hit;
    logic periodic;
  } slot_flags_t;

endpackage

FILE: rtl/tpss_cell.sv
module tpss_cell
  import tpss_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  kind_t                 d_kind,
  input  logic [COUNT_BITS-1:0] d_tick,
  input  logic [COUNT_BITS-1:0] d_period,
  input  logic [COUNT_BITS-1:0] d_beat,
  output kind_t                 q_kind,
  output logic [COUNT_BITS-1:0] q_tick,
  output logic [COUNT_BITS-1:0] q_period,
  output logic [COUNT_BITS-1:0] q_beat
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_kind   <= KIND_INVALID;
      q_tick   <= '0;
      q_period <= '0;
      q_beat   <= '0;
    end else if (shift) begin
      q_kind   <= d_kind;
      q_tick   <= d_tick;
      q_period <= d_period;
      q_beat   <= d_beat;
    end
  end

endmodule

FILE: rtl/tpss_slot_unit.sv
module tpss_slot_unit
  import tpss_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  op_t                   op,
  input  logic                  run_flag,
  input  logic                  wr_hit,
  input  kind_t                 wr_kind,
  input  logic [COUNT_BITS-1:0] wr_period,
  input  logic [COUNT_BITS-1:0] wr_beat,
  input  kind_t                 in_kind,
  input  logic [COUNT_BITS-1:0] in_tick,
  input  logic [COUNT_BITS-1:0] in_period,
  input  logic [COUNT_BITS-1:0] in_beat,
  output kind_t                 out_kind,
  output logic [COUNT_BITS-1:0] out_tick,
  output logic [COUNT_BITS-1:0] out_period,
  output logic [COUNT_BITS-1:0] out_beat,
  output slot_flags_t           flags
);

  logic [COUNT_BITS-1:0] tick_inc;
  logic [COUNT_BITS-1:0] tick_new;
  logic                  due;
  logic                  miss;
  logic                  do_tick;

  assign do_tick  = (op == OP_TICK) && run_flag;
  assign tick_inc = (in_tick != '1) ? in_tick + COUNT_BITS'(1) : in_tick;
  assign due      = ((in_kind == KIND_PERIODIC) || (in_kind == KIND_CALLBACK)) &&
                    (tick_inc == in_period);
  assign tick_new = due ? '0 : tick_inc;
  assign miss     = ((in_kind == KIND_PERIODIC) || (in_kind == KIND_EVENT)) &&
                    (tick_new >= in_beat);

  always_comb begin
    out_kind   = in_kind;
    out_tick   = in_tick;
    out_period = in_period;
    out_beat   = in_beat;
    flags      = '0;
    flags.periodic = (in_kind == KIND_PERIODIC);
    if (do_tick) begin
      out_tick          = tick_new;
      flags.miss_hit    = miss;
      flags.release_hit = !miss && due && (in_kind == KIND_PERIODIC);
      flags.fire_hit    = !miss && due && (in_kind == KIND_CALLBACK);
    end else if ((op == OP_REGISTER) && wr_hit) begin
      out_kind   = wr_kind;
      out_tick   = '0;
      out_period = wr_period;
      out_beat   = wr_beat;
    end
  end

endmodule

FILE: rtl/periodic_task_slot_scheduler_core.sv
// Every transaction, whether tick, slot registration, stop or no-op, walks the ring of slot
// cells once, one slot per clock through a single update unit, so busy stays high after start
// is taken until the walk ends, and done pulses for one cycle in the cycle after the walk ends.
// A new transaction may be started in that same done cycle. The result ports are valid
// only while done is high and must be captured then, as the block cannot be held off by
// the receiver.
module periodic_task_slot_scheduler_core
  import tpss_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation,
  input  logic [4:0]        slot_index,
  input  logic [2:0]        slot_kind,
  input  logic [15:0]       run_period,
  input  logic [15:0]       beat_limit,
  output logic              done,
  output logic [MASK_W-1:0] release_mask,
  output logic [MASK_W-1:0] fire_mask,
  output logic [MASK_W-1:0] scheduled_seen,
  output logic [MASK_W-1:0] missed_seen,
  output logic [1:0]        result_code,
  output logic              still_running
);

  localparam int CNT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SLOT_COUNT - 1);

  kind_t                 c_kind   [SLOT_COUNT];
  logic [COUNT_BITS-1:0] c_tick   [SLOT_COUNT];
  logic [COUNT_BITS-1:0] c_period [SLOT_COUNT];
  logic [COUNT_BITS-1:0] c_beat   [SLOT_COUNT];

  kind_t                 u_kind;
  logic [COUNT_BITS-1:0] u_tick;
  logic [COUNT_BITS-1:0] u_period;
  logic [COUNT_BITS-1:0] u_beat;
  slot_flags_t           flags;

  op_t                   op;
  logic                  wr_en;
  kind_t                 wr_kind;
  logic [COUNT_BITS-1:0] wr_period;
  logic [COUNT_BITS-1:0] wr_beat;
  logic [4:0]            wr_index;
  logic [CNT_W-1:0]      cnt;
  logic                  run_flag;
  code_t                 code;
  logic [MASK_W-1:0]     rel_acc;
  logic [MASK_W-1:0]     fire_acc;
  logic [MASK_W-1:0]     sched_bits;
  logic [MASK_W-1:0]     missed_bits;

  logic                  accept;
  op_t                   op_in;
  kind_t                 kind_in;
  logic [COUNT_BITS-1:0] per_in;
  logic [COUNT_BITS-1:0] beat_in;
  logic                  idx_ok;
  logic                  reject;
  logic                  wr_hit;
  logic [MASK_W-1:0]     slot_bit;

  assign accept  = start && !busy;
  assign op_in   = op_t'(operation);
  assign kind_in = (slot_kind > KIND_MONITOR) ? KIND_INVALID : kind_t'(slot_kind);
  assign per_in  = COUNT_BITS'(run_period);
  assign beat_in = COUNT_BITS'(beat_limit);
  assign idx_ok  = IDX_CMP_W'(slot_index) < IDX_CMP_W'(SLOT_COUNT);
  assign reject  = (kind_in == KIND_PERIODIC) && (per_in == '0);
  assign wr_hit  = wr_en && (IDX_CMP_W'(cnt) == IDX_CMP_W'(wr_index));
  assign slot_bit = (IDX_CMP_W'(cnt) < IDX_CMP_W'(MASK_W)) ?
                    (MASK_W'(1) << IDX_CMP_W'(cnt)) : '0;

  tpss_slot_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) u_unit (
    .op        (op),
    .run_flag  (run_flag),
    .wr_hit    (wr_hit),
    .wr_kind   (wr_kind),
    .wr_period (wr_period),
    .wr_beat   (wr_beat),
    .in_kind   (c_kind[0]),
    .in_tick   (c_tick[0]),
    .in_period (c_period[0]),
    .in_beat   (c_beat[0]),
    .out_kind  (u_kind),
    .out_tick  (u_tick),
    .out_period(u_period),
    .out_beat  (u_beat),
    .flags     (flags)
  );

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    if (i == SLOT_COUNT - 1) begin : g_tail
      tpss_cell #(
        .COUNT_BITS(COUNT_BITS)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (busy),
        .d_kind  (u_kind),
        .d_tick  (u_tick),
        .d_period(u_period),
        .d_beat  (u_beat),
        .q_kind  (c_kind[i]),
        .q_tick  (c_tick[i]),
        .q_period(c_period[i]),
        .q_beat  (c_beat[i])
      );
    end else begin : g_body
      tpss_cell #(
        .COUNT_BITS(COUNT_BITS)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (busy),
        .d_kind  (c_kind[i+1]),
        .d_tick  (c_tick[i+1]),
        .d_period(c_period[i+1]),
        .d_beat  (c_beat[i+1]),
        .q_kind  (c_kind[i]),
        .q_tick  (c_tick[i]),
        .q_period(c_period[i]),
        .q_beat  (c_beat[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      done        <= 1'b0;
      cnt         <= '0;
      run_flag    <= 1'b1;
      code        <= CODE_OK;
      op          <= OP_NONE;
      wr_en       <= 1'b0;
      rel_acc     <= '0;
      fire_acc    <= '0;
      sched_bits  <= '0;
      missed_bits <= '0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        busy     <= 1'b1;
        cnt      <= '0;
        op       <= op_in;
        rel_acc  <= '0;
        fire_acc <= '0;
        wr_en    <= (op_in == OP_REGISTER) && idx_ok && !reject;
        if ((op_in == OP_REGISTER) && idx_ok && reject) begin
          code <= CODE_REJECT;
        end else if ((op_in == OP_TICK) && !run_flag) begin
          code <= CODE_STOPPED;
        end else begin
          code <= CODE_OK;
        end
        if (op_in == OP_STOP) begin
          run_flag <= 1'b0;
        end
      end else if (busy) begin
        if (flags.release_hit) begin
          rel_acc    <= rel_acc | slot_bit;
          sched_bits <= sched_bits | slot_bit;
        end
        if (flags.fire_hit) begin
          fire_acc <= fire_acc | slot_bit;
        end
        if (flags.miss_hit) begin
          missed_bits <= missed_bits | slot_bit;
        end
        if ((op == OP_STOP) && flags.periodic) begin
          rel_acc <= rel_acc | slot_bit;
        end
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_index  <= slot_index;
      wr_kind   <= kind_in;
      wr_period <= ((kind_in == KIND_PERIODIC) || (kind_in == KIND_CALLBACK)) ? per_in : '0;
      wr_beat   <= ((kind_in == KIND_PERIODIC) || (kind_in == KIND_EVENT)) ? beat_in : '0;
    end
  end

  assign release_mask   = rel_acc;
  assign fire_mask      = fire_acc;
  assign scheduled_seen = sched_bits;
  assign missed_seen    = missed_bits;
  assign result_code    = code;
  assign still_running  = run_flag;

  a_done_idle : assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Result strobe raised while a walk is in progress.");

  a_walk_end : assert property (@(posedge clk) disable iff (rst)
    (busy && (cnt == LAST)) |=> done)
    else $error("Walk ended without a result strobe.");

  a_done_single : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("Result strobe held for more than one cycle.");

  a_start_takes : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not start a walk.");

  a_stop_sticky : assert property (@(posedge clk) disable iff (rst)
    !run_flag |=> !run_flag)
    else $error("Scheduler resumed running after a stop.");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tpss_pkg::*;

  localparam int SLOTS = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int GAP_CAP = 60;

  typedef struct {
    logic [31:0] release_bits;
    logic [31:0] fire_bits;
    logic [31:0] sched_bits;
    logic [31:0] missed_bits;
    code_t       code;
    logic        running;
  } sched_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = '0;
  logic [4:0]  slot_index = '0;
  logic [2:0]  slot_kind = '0;
  logic [15:0] run_period = '0;
  logic [15:0] beat_limit = '0;
  logic        done;
  logic [31:0] release_mask;
  logic [31:0] fire_mask;
  logic [31:0] scheduled_seen;
  logic [31:0] missed_seen;
  logic [1:0]  result_code;
  logic        still_running;

  kind_t       slot_kind_tab [SLOTS];
  logic [15:0] slot_count_tab [SLOTS];
  logic [15:0] slot_period_tab [SLOTS];
  logic [15:0] slot_beat_tab [SLOTS];
  logic [31:0] sched_sticky = '0;
  logic [31:0] missed_sticky = '0;
  logic        sched_running = 1'b1;

  sched_result_t expected_results [$];

  int errors = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int n_tick = 0;
  int n_register = 0;
  int n_reject = 0;
  int n_stop = 0;
  int n_release = 0;
  int n_fire = 0;

  periodic_task_slot_scheduler_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .slot_index     (slot_index),
    .slot_kind      (slot_kind),
    .run_period     (run_period),
    .beat_limit     (beat_limit),
    .done           (done),
    .release_mask   (release_mask),
    .fire_mask      (fire_mask),
    .scheduled_seen (scheduled_seen),
    .missed_seen    (missed_seen),
    .result_code    (result_code),
    .still_running  (still_running)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_kind_tab[i] = KIND_INVALID;
      slot_count_tab[i] = '0;
      slot_period_tab[i] = '0;
      slot_beat_tab[i] = '0;
    end
  end

  function automatic sched_result_t predict_result(op_t op, logic [4:0] idx,
                                                   logic [2:0] kind_in, logic [15:0] per,
                                                   logic [15:0] beat);
    sched_result_t res;
    kind_t kind;
    logic due;
    logic miss;
    res.release_bits = '0;
    res.fire_bits = '0;
    res.code = CODE_OK;
    case (op)
      OP_TICK: begin
        n_tick++;
        if (!sched_running) begin
          res.code = CODE_STOPPED;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            due = 1'b0;
            miss = 1'b0;
            if (slot_count_tab[i] != '1) slot_count_tab[i] = slot_count_tab[i] + 16'd1;
            if (slot_kind_tab[i] == KIND_PERIODIC || slot_kind_tab[i] == KIND_CALLBACK) begin
              if (slot_count_tab[i] == slot_period_tab[i]) begin
                due = 1'b1;
                slot_count_tab[i] = '0;
              end
            end
            if (slot_kind_tab[i] == KIND_PERIODIC || slot_kind_tab[i] == KIND_EVENT) begin
              if (slot_count_tab[i] >= slot_beat_tab[i]) miss = 1'b1;
            end
            if (miss) begin
              missed_sticky[i] = 1'b1;
            end else if (due) begin
              if (slot_kind_tab[i] == KIND_PERIODIC) begin
                res.release_bits[i] = 1'b1;
                sched_sticky[i] = 1'b1;
              end else begin
                res.fire_bits[i] = 1'b1;
              end
            end
          end
          if (res.release_bits != '0) n_release++;
          if (res.fire_bits != '0) n_fire++;
        end
      end
      OP_REGISTER: begin
        n_register++;
        kind = (kind_in > 3'd4) ? KIND_INVALID : kind_t'(kind_in);
        if (kind == KIND_PERIODIC && per == '0) begin
          res.code = CODE_REJECT;
          n_reject++;
        end else begin
          if (kind != KIND_PERIODIC && kind != KIND_CALLBACK) per = '0;
          if (kind != KIND_PERIODIC && kind != KIND_EVENT) beat = '0;
          slot_kind_tab[idx] = kind;
          slot_count_tab[idx] = '0;
          slot_period_tab[idx] = per;
          slot_beat_tab[idx] = beat;
        end
      end
      OP_STOP: begin
        n_stop++;
        sched_running = 1'b0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_kind_tab[i] == KIND_PERIODIC) res.release_bits[i] = 1'b1;
      end
      default: ;
    endcase
    res.sched_bits = sched_sticky;
    res.missed_bits = missed_sticky;
    res.running = sched_running;
    return res;
  endfunction

  task automatic send_item(op_t op, logic [4:0] idx, logic [2:0] kind, logic [15:0] per,
                           logic [15:0] beat);
    int gap;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    slot_index <= idx;
    slot_kind <= kind;
    run_period <= per;
    beat_limit <= beat;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected_results.push_back(predict_result(op, idx, kind, per, beat));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("Mismatch on %s at cycle %0d: expected %h, got %h",
                 name, cycle_count, want, got);
    end
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result with no transaction outstanding at cycle %0d",
                                   cycle_count);
      end else begin
        want = expected_results.pop_front();
        check_field("release_mask", want.release_bits, release_mask);
        check_field("fire_mask", want.fire_bits, fire_mask);
        check_field("scheduled_seen", want.sched_bits, scheduled_seen);
        check_field("missed_seen", want.missed_bits, missed_seen);
        check_field("result_code", 32'(want.code), 32'(result_code));
        check_field("still_running", 32'(want.running), 32'(still_running));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_slot_registration();
    send_item(OP_REGISTER, 5'd0, KIND_PERIODIC, 16'd1, 16'hFFFF);
    send_item(OP_REGISTER, 5'd31, KIND_PERIODIC, 16'hFFFF, 16'hFFFF);
    send_item(OP_REGISTER, 5'd5, KIND_PERIODIC, 16'd0, 16'd4);
    send_item(OP_REGISTER, 5'd7, 3'd7, 16'd3, 16'd3);
    send_item(OP_REGISTER, 5'd8, KIND_INVALID, 16'd5, 16'd5);
    send_item(OP_REGISTER, 5'd9, KIND_MONITOR, 16'hFFFF, 16'hFFFF);
    send_item(OP_REGISTER, 5'd10, KIND_EVENT, 16'd7, 16'd0);
    send_item(OP_REGISTER, 5'd11, KIND_CALLBACK, 16'd0, 16'd3);
    send_item(OP_REGISTER, 5'd12, KIND_CALLBACK, 16'd2, 16'd9);
    send_item(OP_REGISTER, 5'd13, KIND_PERIODIC, 16'd3, 16'd2);
    send_item(OP_REGISTER, 5'd14, KIND_EVENT, 16'd1, 16'd3);
    send_item(OP_REGISTER, 5'd15, 3'd5, 16'd2, 16'd2);
    send_item(OP_NONE, 5'd31, 3'd7, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_directed_ticks();
    repeat (7) send_item(OP_TICK, 5'd0, 3'd0, 16'd0, 16'd0);
  endtask

  task automatic test_random_traffic(int pct, int count);
    int sent;
    int pick;
    logic [2:0] kind;
    logic [15:0] per;
    logic [15:0] beat;
    idle_pct = pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(OP_NONE, 5'($urandom), 3'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 38) begin
        kind = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(4, 1));
        per = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(12));
        beat = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(30));
        send_item(OP_REGISTER, 5'($urandom_range(31)), kind, per, beat);
        sent++;
      end else begin
        send_item(OP_TICK, 5'($urandom), 3'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_stop_behaviour();
    idle_pct = 0;
    send_item(OP_STOP, 5'd0, 3'd0, 16'd0, 16'd0);
    send_item(OP_TICK, 5'd0, 3'd0, 16'd0, 16'd0);
    send_item(OP_STOP, 5'd31, 3'd7, 16'hFFFF, 16'hFFFF);
    send_item(OP_REGISTER, 5'd20, KIND_PERIODIC, 16'd2, 16'd40);
    send_item(OP_TICK, 5'd3, 3'd1, 16'd1, 16'd1);
    send_item(OP_STOP, 5'd0, 3'd0, 16'd0, 16'd0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_slot_registration();
    test_directed_ticks();
    test_random_traffic(0, 590);
    wait_for_results();
    test_random_traffic(85, 580);
    wait_for_results();
    test_random_traffic(14, 580);
    test_stop_behaviour();
    wait_for_results();
    repeat (40) @(posedge clk);
    errors += expected_results.size();
    $display("Covered %0d ticks, %0d slot registrations (%0d rejected) and %0d stops.",
             n_tick, n_register, n_reject, n_stop);
    $display("Ticks releasing periodic slots: %0d, ticks firing callbacks: %0d, cycles: %0d.",
             n_release, n_fire, cycle_count);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
